### rtl/i2da_pkg.sv
// ----------------------------------------------------------------------------
// i2da_pkg
// Shared constants and helpers for the integer to decimal text converter.
// ----------------------------------------------------------------------------
package i2da_pkg;

	// default width of the input value
	localparam int VALUE_BITS_DEF = 32;

	// ascii codes
	localparam logic [7:0] CHAR_MINUS = 8'd45;
	localparam logic [7:0] CHAR_ZERO  = 8'd48;

	// largest decimal digit
	localparam logic [3:0] DIGIT_MAX = 4'd9;

	// digits needed for a magnitude of up to 2**(bits-1), log10(2) ~ 0.30103
	function automatic int digits_for(input int bits);
		return ((bits - 1) * 30103) / 100000 + 1;
	endfunction

	// double-dabble correction of one bcd digit before the shift
	function automatic logic [3:0] bcd_adjust(input logic [3:0] d);
		return (d >= 4'd5) ? d + 4'd3 : d;
	endfunction

endpackage

### rtl/integer_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// integer_to_decimal_ascii
// Converts a signed two's complement value to its decimal ascii text, sent
// one character per output word, with last set on the final character.
// ----------------------------------------------------------------------------
// One value is taken at a time. After acceptance it passes through a
// shift-and-add-3 (double-dabble) binary to bcd converter that moves one bit
// per cycle, then a scan that drops leading zero digits one per cycle and
// finds the first significant digit, then a minus sign for a negative value,
// then the real digits, sent one per cycle while the output is not stalled.
// The next value is accepted the cycle after the final character has been
// loaded into the output register.
module integer_to_decimal_ascii #(
	parameter int VALUE_BITS = i2da_pkg::VALUE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [VALUE_BITS-1:0] value,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [7:0]            character,
	output logic                  last
);

	localparam int DIGITS   = i2da_pkg::digits_for(VALUE_BITS);
	localparam int BCD_BITS = DIGITS * 4;
	localparam int CW       = $clog2(VALUE_BITS);
	localparam int DW       = $clog2(DIGITS + 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_CONV = 3'd1;
	localparam logic [2:0] ST_SKIP = 3'd2;
	localparam logic [2:0] ST_SIGN = 3'd3;
	localparam logic [2:0] ST_EMIT = 3'd4;

	logic [2:0]            state_q;
	logic [VALUE_BITS-1:0] bin_q;
	logic [BCD_BITS-1:0]   bcd_q;
	logic [BCD_BITS-1:0]   bcd_adj;
	logic [CW-1:0]         bit_cnt_q;
	logic [DW-1:0]         dig_cnt_q;
	logic                  neg_q;
	logic                  out_valid_q;
	logic [7:0]            char_q;
	logic                  last_q;
	logic                  in_take;
	logic                  slot_free;
	logic                  out_load;
	logic [3:0]            top_digit;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_take   = in_valid && !in_stall;
	assign slot_free = !out_valid_q || !out_stall;
	assign out_load  = slot_free && (state_q == ST_SIGN || state_q == ST_EMIT);
	assign top_digit = bcd_q[BCD_BITS-1 -: 4];

	assign out_valid = out_valid_q;
	assign character = char_q;
	assign last      = last_q;

	// add-3 correction on every bcd digit
	always_comb begin
		for (int i = 0; i < DIGITS; i++) begin
			bcd_adj[i*4 +: 4] = i2da_pkg::bcd_adjust(bcd_q[i*4 +: 4]);
		end
	end

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			bit_cnt_q   <= '0;
			dig_cnt_q   <= '0;
			neg_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// output word register: load a new word or hand the old one off
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						neg_q     <= value[VALUE_BITS-1];
						bit_cnt_q <= '0;
						state_q   <= ST_CONV;
					end
				end
				ST_CONV: begin
					bit_cnt_q <= bit_cnt_q + 1'b1;
					if (bit_cnt_q == CW'(VALUE_BITS - 1)) begin
						dig_cnt_q <= DW'(DIGITS);
						state_q   <= ST_SKIP;
					end
				end
				ST_SKIP: begin
					if (top_digit == 4'd0 && dig_cnt_q > DW'(1)) begin
						dig_cnt_q <= dig_cnt_q - 1'b1;
					end else begin
						state_q <= neg_q ? ST_SIGN : ST_EMIT;
					end
				end
				ST_SIGN: begin
					if (slot_free) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (slot_free) begin
						dig_cnt_q <= dig_cnt_q - 1'b1;
						if (dig_cnt_q == DW'(1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath: magnitude shifter, bcd shifter and output word
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_take) begin
					bin_q <= value[VALUE_BITS-1] ? (~value + 1'b1) : value;
					bcd_q <= '0;
				end
			end
			ST_CONV: begin
				bcd_q <= {bcd_adj[BCD_BITS-2:0], bin_q[VALUE_BITS-1]};
				bin_q <= {bin_q[VALUE_BITS-2:0], 1'b0};
			end
			ST_SKIP: begin
				if (top_digit == 4'd0 && dig_cnt_q > DW'(1)) begin
					bcd_q <= {bcd_q[BCD_BITS-5:0], 4'd0};
				end
			end
			ST_SIGN: begin
				if (slot_free) begin
					char_q <= i2da_pkg::CHAR_MINUS;
					last_q <= 1'b0;
				end
			end
			ST_EMIT: begin
				if (slot_free) begin
					char_q <= i2da_pkg::CHAR_ZERO + {4'd0, top_digit};
					last_q <= (dig_cnt_q == DW'(1));
					bcd_q  <= {bcd_q[BCD_BITS-5:0], 4'd0};
				end
			end
			default: begin
			end
		endcase
	end

	// accepted value always enters conversion
	a_take_conv: assert property (@(posedge clk) disable iff (!arst_n)
		in_take |=> state_q == ST_CONV)
		else $error("accepted value did not start conversion");

	// conversion ends after exactly VALUE_BITS shifts
	a_conv_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CONV && bit_cnt_q == CW'(VALUE_BITS - 1)) |=> state_q == ST_SKIP)
		else $error("conversion did not hand over to digit scan");

	// output word is a minus sign or a decimal digit
	a_char_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (character == i2da_pkg::CHAR_MINUS && !last) ||
			(character >= i2da_pkg::CHAR_ZERO &&
			 character <= i2da_pkg::CHAR_ZERO + {4'd0, i2da_pkg::DIGIT_MAX}))
		else $error("illegal character on output");

endmodule

### bench/integer_to_decimal_ascii_tb.sv
// ----------------------------------------------------------------------------
// integer_to_decimal_ascii_tb
// Self-checking bench for the integer to decimal text converter. Directed
// extremes come from a table, then random values of every digit count. Each
// accepted value is turned into the character words it should produce, and
// every output word is compared against the oldest one still waiting.
// ----------------------------------------------------------------------------
module integer_to_decimal_ascii_tb;

	localparam int VBITS      = i2da_pkg::VALUE_BITS_DEF;
	localparam int RAND_ITEMS = 80;
	localparam int QUIET_TAIL = 20;
	localparam int DRAIN_CYC  = 60;
	localparam int MAX_SHOWN  = 10;

	// one expected output word
	typedef struct {
		logic [7:0] character;
		logic       last;
	} char_word_t;

	// one directed row, text left empty where the predictor decides
	typedef struct {
		logic [VBITS-1:0] value;
		string            text;
	} text_row_t;

	localparam int N_ROWS = 20;

	text_row_t directed_rows [N_ROWS] = '{
		'{32'd0,          "0"},
		'{32'd1,          "1"},
		'{32'hFFFFFFFF,   "-1"},
		'{32'd9,          "9"},
		'{32'd10,         "10"},
		'{32'h7FFFFFFF,   "2147483647"},
		'{32'h80000001,   "-2147483647"},
		'{32'h80000000,   "-2147483648"},
		'{-32'sd10,       ""},
		'{-32'sd9,        ""},
		'{32'd99,         ""},
		'{32'd100,        ""},
		'{32'd999999999,  ""},
		'{32'd1000000000, ""},
		'{-32'sd999999999, ""},
		'{-32'sd1000000000, ""},
		'{32'h55555555,   ""},
		'{32'hAAAAAAAA,   ""},
		'{32'h0000FFFF,   ""},
		'{32'hFFFF0000,   ""}
	};

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             in_valid  = 1'b0;
	logic             in_stall;
	logic [VBITS-1:0] value     = '0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	logic [7:0]       character;
	logic             last;

	char_word_t pending_chars [$];
	bit         quiet       = 1'b0;
	int         mismatches  = 0;
	int         values_sent = 0;
	int         negatives   = 0;
	int         chars_seen  = 0;

	integer_to_decimal_ascii #(
		.VALUE_BITS(VBITS)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.value    (value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.character(character),
		.last     (last)
	);

	// clock
	initial begin
		forever #4 clk = ~clk;
	end

	// run limit
	initial begin
		#2000000;
		$display("run limit reached with %0d words outstanding", pending_chars.size());
		$display("TEST FAILED");
		$finish;
	end

	// decimal text predictor: sign, then digits most significant first
	function automatic void queue_decimal_text(input logic [VBITS-1:0] v);
		logic [VBITS:0] mag;
		logic [3:0]     digits [$];
		char_word_t     w;
		int             i;
		// one bit wider so the most negative value negates cleanly
		mag = v[VBITS-1] ? ({1'b0, ~v} + 1'b1) : {1'b0, v};
		do begin
			digits.push_back(4'(mag % 33'd10));
			mag = mag / 33'd10;
		end while (mag != 0);
		if (v[VBITS-1]) begin
			w.character = i2da_pkg::CHAR_MINUS;
			w.last      = 1'b0;
			pending_chars.push_back(w);
		end
		for (i = digits.size() - 1; i >= 0; i--) begin
			w.character = i2da_pkg::CHAR_ZERO + 8'(digits[i]);
			w.last      = (i == 0);
			pending_chars.push_back(w);
		end
	endfunction

	// expectation typed in as text
	function automatic void queue_literal_text(input string s);
		char_word_t w;
		int         i;
		for (i = 0; i < s.len(); i++) begin
			w.character = s[i];
			w.last      = (i == s.len() - 1);
			pending_chars.push_back(w);
		end
	endfunction

	// offer one value, return at the edge that accepts it
	task automatic send_value(input logic [VBITS-1:0] v);
		int gap;
		if (!quiet && $urandom_range(0, 2) == 0) begin
			in_valid <= 1'b0;
			gap = $urandom_range(1, 7);
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		value    <= v;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		values_sent++;
		if (v[VBITS-1]) negatives++;
	endtask

	// random value of a random shape
	function automatic logic [VBITS-1:0] pick_value();
		longint lo;
		longint hi;
		longint mag;
		longint p;
		int     n;
		int     k;
		case ($urandom_range(0, 3))
			0: begin
				mag = longint'($urandom);
				return VBITS'(mag);
			end
			1: begin
				// uniform over a chosen digit count
				n  = $urandom_range(1, 10);
				lo = 1;
				for (k = 1; k < n; k++) lo = lo * 10;
				hi = lo * 10 - 1;
				if (n == 1) lo = 0;
				if (hi > 64'sd2147483647) hi = 64'sd2147483647;
				mag = lo + (longint'({$urandom, $urandom}) & 64'h7FFFFFFFFFFF) % (hi - lo + 1);
				return $urandom_range(0, 1) ? VBITS'(-mag) : VBITS'(mag);
			end
			2: begin
				// around a power of ten
				p = 1;
				k = $urandom_range(0, 9);
				repeat (k) p = p * 10;
				mag = p + $urandom_range(0, 2) - 1;
				return $urandom_range(0, 1) ? VBITS'(-mag) : VBITS'(mag);
			end
			default: begin
				mag = $urandom_range(0, 40);
				return VBITS'(mag - 20);
			end
		endcase
	endfunction

	// output stall bursts, none in the quiet tail
	initial begin
		forever begin
			if (!quiet && $urandom_range(0, 2) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 7)) @(posedge clk);
			end
			out_stall <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	end

	// output word check against the oldest expectation
	always @(posedge clk) begin
		char_word_t w;
		if (arst_n && out_valid && !out_stall) begin
			chars_seen++;
			if (pending_chars.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_SHOWN)
					$display("unexpected word: character %0d last %0d", character, last);
			end else begin
				w = pending_chars.pop_front();
				if (character !== w.character || last !== w.last) begin
					mismatches++;
					if (mismatches <= MAX_SHOWN)
						$display("word mismatch: expected character %0d last %0d, got %0d last %0d",
							w.character, w.last, character, last);
				end
			end
		end
	end

	// stimulus
	initial begin
		int               i;
		logic [VBITS-1:0] v;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (i = 0; i < N_ROWS; i++) begin
			send_value(directed_rows[i].value);
			if (directed_rows[i].text.len() != 0)
				queue_literal_text(directed_rows[i].text);
			else
				queue_decimal_text(directed_rows[i].value);
		end

		// random values, last stretch without idling
		for (i = 0; i < RAND_ITEMS; i++) begin
			if (i >= RAND_ITEMS - QUIET_TAIL) quiet = 1'b1;
			v = pick_value();
			send_value(v);
			queue_decimal_text(v);
		end
		in_valid <= 1'b0;

		// drain
		while (pending_chars.size() != 0) @(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);

		if (pending_chars.size() != 0) mismatches++;
		$display("converted %0d values (%0d negative) into %0d checked characters",
			values_sent, negatives, chars_seen);
		$display("covered extremes, every digit count and random stalls on both sides");
		if (mismatches == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
